[rtl/core/brz_pkg.sv]
// Shared types and constants of the Bresenham line rasterizer.
package brz_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic {
        KIND_LINE = 1'b0,
        KIND_STEP = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  x_neg;
        logic  y_neg;
    } t_cmd_ctl;

    localparam int CTL_BITS = $bits(t_cmd_ctl);

endpackage

[rtl/core/brz_front.sv]
// Front end: unpack an input transfer and form absolute deltas and step directions.
module brz_front #(
    parameter int COORD_BITS = brz_pkg::COORD_BITS_DEF
) (
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] i_tdata,
    input  logic                              i_tuser,
    output brz_pkg::t_cmd_ctl                 o_ctl,
    output logic [COORD_BITS-1:0]             o_start_x,
    output logic [COORD_BITS-1:0]             o_start_y,
    output logic [COORD_BITS-1:0]             o_len_x,
    output logic [COORD_BITS-1:0]             o_len_y
);
    import brz_pkg::*;

    logic [COORD_BITS-1:0] w_end_x;
    logic [COORD_BITS-1:0] w_end_y;
    logic [COORD_BITS:0]   w_dx;
    logic [COORD_BITS:0]   w_dy;
    logic [COORD_BITS:0]   w_abs_dx;
    logic [COORD_BITS:0]   w_abs_dy;

    assign o_start_x = i_tdata[COORD_BITS-1:0];
    assign o_start_y = i_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_end_x   = i_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_end_y   = i_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign w_dx = {w_end_x[COORD_BITS-1], w_end_x} - {o_start_x[COORD_BITS-1], o_start_x};
    assign w_dy = {w_end_y[COORD_BITS-1], w_end_y} - {o_start_y[COORD_BITS-1], o_start_y};

    assign w_abs_dx = w_dx[COORD_BITS] ? ((COORD_BITS+1)'(0) - w_dx) : w_dx;
    assign w_abs_dy = w_dy[COORD_BITS] ? ((COORD_BITS+1)'(0) - w_dy) : w_dy;

    assign o_len_x = w_abs_dx[COORD_BITS-1:0];
    assign o_len_y = w_abs_dy[COORD_BITS-1:0];

    always_comb begin
        o_ctl.kind  = i_tuser ? KIND_STEP : KIND_LINE;
        o_ctl.x_neg = w_dx[COORD_BITS];
        o_ctl.y_neg = w_dy[COORD_BITS];
    end

endmodule

[rtl/core/brz_queue.sv]
// Short command queue between the front end and the pixel stepper.
module brz_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = brz_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    import brz_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] n_count;
    logic                w_push;
    logic                w_pop;

    function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
        next_ptr = (ptr == PTR_BITS'(DEPTH - 1)) ? '0 : ptr + PTR_BITS'(1);
    endfunction

    assign o_push_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = w_push ? next_ptr(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = w_pop  ? next_ptr(r_rd_ptr) : r_rd_ptr;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + CNT_BITS'(1);
            2'b01:   n_count = r_count - CNT_BITS'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/core/brz_back.sv]
// Back end: line setup, Bresenham error stepping and the output register.
module brz_back #(
    parameter int COORD_BITS = brz_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  brz_pkg::t_cmd_ctl     i_ctl,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_len_x,
    input  logic [COORD_BITS-1:0] i_len_y,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last
);
    import brz_pkg::*;

    localparam int ERR_BITS = COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [ERR_BITS-1:0]   r_err, n_err;
    logic [COORD_BITS-1:0] r_major, n_major;
    logic [COORD_BITS-1:0] r_minor, n_minor;
    logic                  r_x_neg, n_x_neg;
    logic                  r_y_neg, n_y_neg;
    logic                  r_y_major, n_y_major;
    logic [COORD_BITS-1:0] r_steps, n_steps;
    logic                  r_active, n_active;
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;
    logic                  r_out_last, n_out_last;

    logic                  w_take;
    logic                  w_line_y_major;
    logic [COORD_BITS-1:0] w_line_major;
    logic [COORD_BITS-1:0] w_line_minor;
    logic [ERR_BITS-1:0]   w_line_err;
    logic                  w_move_minor;
    logic [COORD_BITS-1:0] w_step_x;
    logic [COORD_BITS-1:0] w_step_y;
    logic [ERR_BITS-1:0]   w_err_delta;
    logic [COORD_BITS-1:0] w_steps_dec;

    assign o_cmd_ready = !r_out_valid || i_tready;
    assign w_take      = i_cmd_valid && o_cmd_ready;

    assign w_line_y_major = !(i_len_y < i_len_x);
    assign w_line_major   = w_line_y_major ? i_len_y : i_len_x;
    assign w_line_minor   = w_line_y_major ? i_len_x : i_len_y;
    assign w_line_err     = {1'b0, w_line_minor, 1'b0} - {2'b00, w_line_major};

    assign w_move_minor = !r_err[ERR_BITS-1];
    assign w_step_x     = r_x_neg ? r_cur_x - COORD_BITS'(1) : r_cur_x + COORD_BITS'(1);
    assign w_step_y     = r_y_neg ? r_cur_y - COORD_BITS'(1) : r_cur_y + COORD_BITS'(1);
    assign w_err_delta  = w_move_minor ? ({1'b0, r_minor, 1'b0} - {1'b0, r_major, 1'b0})
                                       : {1'b0, r_minor, 1'b0};
    assign w_steps_dec  = r_steps - COORD_BITS'(1);

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_err       = r_err;
        n_major     = r_major;
        n_minor     = r_minor;
        n_x_neg     = r_x_neg;
        n_y_neg     = r_y_neg;
        n_y_major   = r_y_major;
        n_steps     = r_steps;
        n_active    = r_active;
        n_out_valid = r_out_valid && !i_tready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        if (w_take) begin
            case (i_ctl.kind)
                KIND_LINE: begin
                    n_cur_x     = i_start_x;
                    n_cur_y     = i_start_y;
                    n_err       = w_line_err;
                    n_major     = w_line_major;
                    n_minor     = w_line_minor;
                    n_x_neg     = i_ctl.x_neg;
                    n_y_neg     = i_ctl.y_neg;
                    n_y_major   = w_line_y_major;
                    n_steps     = w_line_major;
                    n_active    = (w_line_major != '0);
                    n_out_valid = 1'b1;
                    n_out_x     = i_start_x;
                    n_out_y     = i_start_y;
                    n_out_last  = (w_line_major == '0);
                end
                KIND_STEP: begin
                    if (r_active) begin
                        if (!r_y_major || w_move_minor) begin
                            n_cur_x = w_step_x;
                        end
                        if (r_y_major || w_move_minor) begin
                            n_cur_y = w_step_y;
                        end
                        n_err       = r_err + w_err_delta;
                        n_steps     = w_steps_dec;
                        n_active    = (w_steps_dec != '0);
                        n_out_valid = 1'b1;
                        n_out_x     = n_cur_x;
                        n_out_y     = n_cur_y;
                        n_out_last  = (w_steps_dec == '0);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x    <= n_cur_x;
        r_cur_y    <= n_cur_y;
        r_err      <= n_err;
        r_major    <= n_major;
        r_minor    <= n_minor;
        r_x_neg    <= n_x_neg;
        r_y_neg    <= n_y_neg;
        r_y_major  <= n_y_major;
        r_steps    <= n_steps;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_tvalid  = r_out_valid;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_last    = r_out_last;

endmodule

[rtl/core/bresenham_line_rasterizer_unit.sv]
// Top level of the Bresenham line rasterizer: front end, command queue, pixel stepper.
// An input transfer is registered in the queue, then in the output register of the stepper.
// One item per cycle unless the output register is stalled; each step updates the error term.
// Step items that arrive while no line is active leave without producing a pixel.
// Reset (i_rst_n low, synchronous) empties the queue, ends any line and clears m_axis_tvalid.
module bresenham_line_rasterizer_unit #(
    parameter int COORD_BITS = brz_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,  // start_x, start_y, end_x, end_y
    input  logic                                  s_axis_tuser,  // kind
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata,  // pixel_x, pixel_y
    output logic                                  m_axis_tlast
);
    import brz_pkg::*;

    localparam int CMD_BITS = CTL_BITS + 4 * COORD_BITS;

    t_cmd_ctl              w_front_ctl;
    logic [COORD_BITS-1:0] w_front_sx;
    logic [COORD_BITS-1:0] w_front_sy;
    logic [COORD_BITS-1:0] w_front_lx;
    logic [COORD_BITS-1:0] w_front_ly;
    logic [CMD_BITS-1:0]   w_push_data;
    logic [CMD_BITS-1:0]   w_pop_data;
    logic                  w_pop_valid;
    logic                  w_pop_ready;
    t_cmd_ctl              w_back_ctl;
    logic [COORD_BITS-1:0] w_back_sx;
    logic [COORD_BITS-1:0] w_back_sy;
    logic [COORD_BITS-1:0] w_back_lx;
    logic [COORD_BITS-1:0] w_back_ly;
    logic [COORD_BITS-1:0] w_pixel_x;
    logic [COORD_BITS-1:0] w_pixel_y;

    brz_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .o_ctl     (w_front_ctl),
        .o_start_x (w_front_sx),
        .o_start_y (w_front_sy),
        .o_len_x   (w_front_lx),
        .o_len_y   (w_front_ly)
    );

    assign w_push_data = {w_front_ctl, w_front_sx, w_front_sy, w_front_lx, w_front_ly};

    brz_queue #(
        .WIDTH(CMD_BITS),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_axis_tvalid),
        .o_push_ready (s_axis_tready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    assign {w_back_ctl, w_back_sx, w_back_sy, w_back_lx, w_back_ly} = w_pop_data;

    brz_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .o_cmd_ready (w_pop_ready),
        .i_ctl       (w_back_ctl),
        .i_start_x   (w_back_sx),
        .i_start_y   (w_back_sy),
        .i_len_x     (w_back_lx),
        .i_len_y     (w_back_ly),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_pixel_x   (w_pixel_x),
        .o_pixel_y   (w_pixel_y),
        .o_last      (m_axis_tlast)
    );

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[COORD_BITS-1:0]            = w_pixel_x;
        m_axis_tdata[2*COORD_BITS-1:COORD_BITS] = w_pixel_y;
    end

endmodule

[rtl/core/brz_checker.sv]
// Port-level checker of the Bresenham line rasterizer and its bind.
module brz_checker #(
    parameter int COORD_BITS = brz_pkg::COORD_BITS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic                              m_axis_tlast
);
    import brz_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("pixel changed while stalled");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("queue filled without an input transfer");

    a_reset_exit: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty after reset");

endmodule

bind bresenham_line_rasterizer_unit brz_checker #(
    .COORD_BITS(COORD_BITS)
) u_brz_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
